[hdl/shortest_arc_quaternion_macros.svh]
`ifndef SHORTEST_ARC_QUATERNION_MACROS_SVH
`define SHORTEST_ARC_QUATERNION_MACROS_SVH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SAQ_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error(msg);
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SAQ_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error(msg);
`endif

[hdl/saq_pkg.sv]
`default_nettype none
package saq_pkg;

    typedef logic [1:0] case_t;

    localparam case_t CASE_IDENTITY = 2'd0;
    localparam case_t CASE_FALLBACK = 2'd1;
    localparam case_t CASE_GENAXIS  = 2'd2;
    localparam case_t CASE_GENERAL  = 2'd3;

    // Cycles from the input of the normalizer to its registered output.
    localparam int UNIT_LAT = 71;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sqrt_t;

    typedef struct packed {
        logic [33:0] r;
        logic        q;
    } div_t;

    // One digit of the bit-pair integer square root.
    function automatic sqrt_t sqrt_step(input logic [63:0] x, input logic [63:0] r,
                                        input logic [63:0] b);
        sqrt_t res;
        if (x >= r + b)
        begin
            res.x = x - (r + b);
            res.r = (r >> 1) + b;
        end
        else
        begin
            res.x = x;
            res.r = r >> 1;
        end
        return res;
    endfunction

    // One quotient bit of a restoring division.
    function automatic div_t div_step(input logic [33:0] r, input logic nb,
                                      input logic [31:0] d);
        logic [34:0] t;
        div_t        res;
        t = {r, nb};
        if (t >= {3'b000, d})
        begin
            res.r = 34'(t - {3'b000, d});
            res.q = 1'b1;
        end
        else
        begin
            res.r = t[33:0];
            res.q = 1'b0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[hdl/saq_in_if.sv]
`default_nettype none
interface saq_in_if #(parameter int WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] src_x;
    logic signed [WIDTH-1:0] src_y;
    logic signed [WIDTH-1:0] src_z;
    logic signed [WIDTH-1:0] to_x;
    logic signed [WIDTH-1:0] to_y;
    logic signed [WIDTH-1:0] to_z;
    logic signed [WIDTH-1:0] fallback_x;
    logic signed [WIDTH-1:0] fallback_y;
    logic signed [WIDTH-1:0] fallback_z;

    modport source (output valid, src_x, src_y, src_z, to_x, to_y, to_z,
                    fallback_x, fallback_y, fallback_z, input ready);
    modport sink (input valid, src_x, src_y, src_z, to_x, to_y, to_z,
                  fallback_x, fallback_y, fallback_z, output ready);
endinterface
`default_nettype wire

[hdl/saq_out_if.sv]
`default_nettype none
interface saq_out_if #(parameter int WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] quat_w;
    logic signed [WIDTH-1:0] quat_x;
    logic signed [WIDTH-1:0] quat_y;
    logic signed [WIDTH-1:0] quat_z;
    logic [1:0]              case_code;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, case_code, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, case_code, output ready);
endinterface
`default_nettype wire

[hdl/saq_unit.sv]
`default_nettype none
// Makes an N-component signed vector unit length in Q2.30. A new vector may
// enter on every enabled cycle.
module saq_unit import saq_pkg::*; #(
    parameter int N  = 3,
    parameter int IW = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [IW-1:0] v [N],
    output logic signed [31:0]        o [N]
);

    localparam int NG   = (IW + 7) / 8;
    localparam int PADW = NG * 8;
    localparam int PW   = $clog2(PADW);
    localparam int SQN  = 32;
    localparam int DVN  = 31;

    logic [IW-1:0]   mag_a [N];
    logic [IW-1:0]   top_a;

    logic [IW-1:0]   mag1_reg [N];
    logic            sgn1_reg [N];
    logic [IW-1:0]   top1_reg;

    logic [IW-1:0]   mag2_reg [N];
    logic            sgn2_reg [N];
    logic            any2_reg [NG];
    logic [2:0]      pos2_reg [NG];

    logic [IW-1:0]   mag3_reg [N];
    logic            sgn3_reg [N];
    logic [PW-1:0]   p3_reg;
    logic            zero3_reg;

    logic [29:0]     mn4_reg [N];
    logic            sgn4_reg [N];
    logic            zero4_reg;

    logic [59:0]     sq5_reg [N];
    logic [29:0]     mn5_reg [N];
    logic            sgn5_reg [N];
    logic            zero5_reg;

    logic [63:0]     sx_reg [SQN+1];
    logic [63:0]     sr_reg [SQN+1];
    logic [29:0]     smn_reg [SQN+1][N];
    logic            ssg_reg [SQN+1][N];
    logic            szr_reg [SQN+1];

    logic [33:0]     dr_reg [DVN+1][N];
    logic [30:0]     dl_reg [DVN+1][N];
    logic [30:0]     dq_reg [DVN+1][N];
    logic [30:0]     dlen_reg [DVN+1];
    logic            dsg_reg [DVN+1][N];
    logic            dzr_reg [DVN+1];

    logic signed [31:0] o_reg [N];

    always_comb
    begin
        top_a = '0;
        for (int i = 0; i < N; i++)
        begin
            mag_a[i] = v[i][IW-1] ? IW'(-v[i]) : IW'(v[i]);
            if (mag_a[i] > top_a)
            begin
                top_a = mag_a[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [PADW-1:0] topp;
        logic [PW-1:0]   p;
        logic [2:0]      pos;
        logic            anyb;
        logic [IW+28:0]  ext;
        logic [63:0]     sum;
        logic [60:0]     num;
        sqrt_t           st;
        div_t            dt;
        if (en)
        begin
            // Magnitudes and the largest one.
            for (int i = 0; i < N; i++)
            begin
                mag1_reg[i] <= mag_a[i];
                sgn1_reg[i] <= v[i][IW-1];
            end
            top1_reg <= top_a;

            // Leading-one search, first inside each byte.
            topp = PADW'(top1_reg);
            for (int g = 0; g < NG; g++)
            begin
                any2_reg[g] <= |topp[g*8 +: 8];
                pos = 3'd0;
                for (int b = 0; b < 8; b++)
                begin
                    if (topp[g*8 + b])
                    begin
                        pos = 3'(b);
                    end
                end
                pos2_reg[g] <= pos;
            end
            mag2_reg <= mag1_reg;
            sgn2_reg <= sgn1_reg;

            // Then across the bytes.
            p    = '0;
            anyb = 1'b0;
            for (int g = 0; g < NG; g++)
            begin
                if (any2_reg[g])
                begin
                    p    = PW'(g * 8) + PW'(pos2_reg[g]);
                    anyb = 1'b1;
                end
            end
            p3_reg    <= p;
            zero3_reg <= !anyb;
            mag3_reg  <= mag2_reg;
            sgn3_reg  <= sgn2_reg;

            // Scale so that the largest magnitude lands in [2^29, 2^30).
            for (int i = 0; i < N; i++)
            begin
                ext         = {mag3_reg[i], 29'b0} >> p3_reg;
                mn4_reg[i] <= ext[29:0];
            end
            sgn4_reg  <= sgn3_reg;
            zero4_reg <= zero3_reg;

            for (int i = 0; i < N; i++)
            begin
                sq5_reg[i] <= mn4_reg[i] * mn4_reg[i];
            end
            mn5_reg   <= mn4_reg;
            sgn5_reg  <= sgn4_reg;
            zero5_reg <= zero4_reg;

            sum = '0;
            for (int i = 0; i < N; i++)
            begin
                sum = sum + 64'(sq5_reg[i]);
            end
            sx_reg[0]  <= sum;
            sr_reg[0]  <= '0;
            smn_reg[0] <= mn5_reg;
            ssg_reg[0] <= sgn5_reg;
            szr_reg[0] <= zero5_reg;

            // Square root of the sum of squares, one digit per stage.
            for (int k = 1; k <= SQN; k++)
            begin
                st = sqrt_step(sx_reg[k-1], sr_reg[k-1], 64'd1 << (2 * (SQN - k)));
                sx_reg[k]  <= st.x;
                sr_reg[k]  <= st.r;
                smn_reg[k] <= smn_reg[k-1];
                ssg_reg[k] <= ssg_reg[k-1];
                szr_reg[k] <= szr_reg[k-1];
            end

            // Rounded quotient mag * 2^30 / len; it stays below 2^31.
            for (int i = 0; i < N; i++)
            begin
                num = {smn_reg[SQN][i], 30'b0} + 61'(sr_reg[SQN][30:1]);
                dr_reg[0][i] <= 34'(num[60:31]);
                dl_reg[0][i] <= num[30:0];
                dq_reg[0][i] <= '0;
            end
            dlen_reg[0] <= sr_reg[SQN][30:0];
            dsg_reg[0]  <= ssg_reg[SQN];
            dzr_reg[0]  <= szr_reg[SQN];

            for (int k = 1; k <= DVN; k++)
            begin
                for (int i = 0; i < N; i++)
                begin
                    dt = div_step(dr_reg[k-1][i], dl_reg[k-1][i][30], {1'b0, dlen_reg[k-1]});
                    dr_reg[k][i] <= dt.r;
                    dl_reg[k][i] <= {dl_reg[k-1][i][29:0], 1'b0};
                    dq_reg[k][i] <= {dq_reg[k-1][i][29:0], dt.q};
                end
                dlen_reg[k] <= dlen_reg[k-1];
                dsg_reg[k]  <= dsg_reg[k-1];
                dzr_reg[k]  <= dzr_reg[k-1];
            end

            // A zero vector stays zero.
            for (int i = 0; i < N; i++)
            begin
                if (dzr_reg[DVN])
                begin
                    o_reg[i] <= '0;
                end
                else if (dsg_reg[DVN][i])
                begin
                    o_reg[i] <= -$signed({1'b0, dq_reg[DVN][i]});
                end
                else
                begin
                    o_reg[i] <= $signed({1'b0, dq_reg[DVN][i]});
                end
            end
        end
    end

    assign o = o_reg;

endmodule
`default_nettype wire

[hdl/shortest_arc_quaternion.sv]
// Shortest-arc rotation quaternion, fully pipelined over 221 register stages.
// Throughput is one beat per cycle; the whole pipe holds while the output beat waits.
// The depth comes from the normalizers and the square root and divider, one digit per stage.
// Reset clears only the stage valid bits; the data registers are not reset.
`default_nettype none
module shortest_arc_quaternion import saq_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    saq_in_if.sink     req,
    saq_out_if.source  rsp
);

    localparam int CB       = COMPONENT_BITS;
    localparam int AXW      = CB + 1;
    localparam int RAW_W    = 48;
    localparam int DOTW     = 38;
    localparam int SQN      = 32;
    localparam int QTN      = 40;
    localparam int U        = UNIT_LAT;
    localparam int S_P1     = U + 1;
    localparam int S_P2     = U + 2;
    localparam int S_P3     = U + 3;
    localparam int S_P4     = U + 4;
    localparam int S_SQ_END = S_P4 + SQN;
    localparam int S_DI     = S_SQ_END + 1;
    localparam int S_DV_END = S_DI + QTN;
    localparam int S_RAW    = S_DV_END + 1;
    localparam int S_FU     = S_RAW + U;
    localparam int S_OUT    = S_FU + 1;
    localparam int RSH      = 30 - FRACTION_BITS;

    localparam logic signed [DOTW-1:0] DOT_ONE = DOTW'(64'sd1 <<< 30);
    localparam logic signed [DOTW-1:0] DOT_OPP =
        DOTW'(-(64'sd1 <<< 30) + (64'sd1 <<< RSH));
    localparam logic [32:0] HALF = 33'(33'd1 << RSH) >> 1;

    logic en;

    logic signed [CB-1:0] a_in [3];
    logic signed [CB-1:0] b_in [3];
    logic signed [CB-1:0] f_in [3];
    logic signed [AXW-1:0] ax_in [3];
    logic                  fbn_in;

    logic signed [31:0] na [3];
    logic signed [31:0] nb [3];
    logic signed [31:0] qo [4];

    logic            vld_reg [1:S_OUT];
    logic signed [AXW-1:0] axr_reg [1:S_DV_END][3];
    logic                  fbn_reg [1:S_DV_END];

    logic signed [63:0] pdot_reg [3];
    logic signed [63:0] pcr_reg [6];
    logic signed [65:0] d60_reg;
    logic signed [64:0] cr2_reg [3];
    logic signed [DOTW-1:0] dot_reg;
    logic signed [64:0] cr3_reg [3];

    case_t           code_reg [S_P4:S_OUT];
    logic [63:0]     sx_reg [S_P4:S_SQ_END];
    logic [63:0]     sr_reg [S_P4:S_SQ_END];
    logic [63:0]     cm_reg [S_P4:S_SQ_END][3];
    logic            cs_reg [S_P4:S_DV_END][3];

    logic [33:0]     dr_reg [S_DI:S_DV_END][3];
    logic [39:0]     dl_reg [S_DI:S_DV_END][3];
    logic [39:0]     dq_reg [S_DI:S_DV_END][3];
    logic [31:0]     sv_reg [S_DI:S_DV_END];

    logic signed [RAW_W-1:0] raw_reg [4];
    logic [CB-1:0]           oq_reg [4];

    assign en        = !vld_reg[S_OUT] || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        a_in[0] = req.src_x;
        a_in[1] = req.src_y;
        a_in[2] = req.src_z;
        b_in[0] = req.to_x;
        b_in[1] = req.to_y;
        b_in[2] = req.to_z;
        f_in[0] = req.fallback_x;
        f_in[1] = req.fallback_y;
        f_in[2] = req.fallback_z;
        fbn_in  = (f_in[0] != '0) || (f_in[1] != '0) || (f_in[2] != '0);
        // Half-turn axis: the fallback, else X cross source, else Y cross source.
        if (fbn_in)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ax_in[i] = AXW'(f_in[i]);
            end
        end
        else if (a_in[2] != '0 || a_in[1] != '0)
        begin
            ax_in[0] = '0;
            ax_in[1] = -AXW'(a_in[2]);
            ax_in[2] = AXW'(a_in[1]);
        end
        else
        begin
            ax_in[0] = AXW'(a_in[2]);
            ax_in[1] = '0;
            ax_in[2] = -AXW'(a_in[0]);
        end
    end

    saq_unit #(.N(3), .IW(CB)) u_src (.clk(clk), .en(en), .v(a_in), .o(na));
    saq_unit #(.N(3), .IW(CB)) u_dst (.clk(clk), .en(en), .v(b_in), .o(nb));
    saq_unit #(.N(4), .IW(RAW_W)) u_quat (.clk(clk), .en(en), .v(raw_reg), .o(qo));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= S_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= req.valid;
            for (int k = 2; k <= S_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [65:0]        mag66;
        logic [65:0]        rnd66;
        logic signed [DOTW:0] tplus;
        logic [63:0]        num;
        logic [32:0]        mag33;
        logic [32:0]        rnd33;
        logic [32:0]        val33;
        sqrt_t              st;
        div_t               dt;
        if (en)
        begin
            axr_reg[1] <= ax_in;
            fbn_reg[1] <= fbn_in;
            for (int k = 2; k <= S_DV_END; k++)
            begin
                axr_reg[k] <= axr_reg[k-1];
                fbn_reg[k] <= fbn_reg[k-1];
            end

            pdot_reg[0] <= na[0] * nb[0];
            pdot_reg[1] <= na[1] * nb[1];
            pdot_reg[2] <= na[2] * nb[2];
            pcr_reg[0]  <= na[1] * nb[2];
            pcr_reg[1]  <= na[2] * nb[1];
            pcr_reg[2]  <= na[2] * nb[0];
            pcr_reg[3]  <= na[0] * nb[2];
            pcr_reg[4]  <= na[0] * nb[1];
            pcr_reg[5]  <= na[1] * nb[0];

            d60_reg <= 66'(pdot_reg[0]) + 66'(pdot_reg[1]) + 66'(pdot_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                cr2_reg[i] <= 65'(pcr_reg[2*i]) - 65'(pcr_reg[2*i+1]);
            end

            // Dot product back to Q2.30, rounded half away from zero.
            mag66 = d60_reg[65] ? 66'(-d60_reg) : 66'(d60_reg);
            rnd66 = (mag66 + (66'd1 << 29)) >> 30;
            dot_reg <= d60_reg[65] ? -$signed(rnd66[DOTW-1:0]) : $signed(rnd66[DOTW-1:0]);
            cr3_reg <= cr2_reg;

            priority if (dot_reg >= DOT_ONE)
            begin
                code_reg[S_P4] <= CASE_IDENTITY;
            end
            else if (dot_reg < DOT_OPP)
            begin
                code_reg[S_P4] <= fbn_reg[S_P3] ? CASE_FALLBACK : CASE_GENAXIS;
            end
            else
            begin
                code_reg[S_P4] <= CASE_GENERAL;
            end
            for (int k = S_P4 + 1; k <= S_OUT; k++)
            begin
                code_reg[k] <= code_reg[k-1];
            end

            // Radicand 2(1 + d) in Q2.60.
            tplus = (DOTW+1)'(DOT_ONE) + (DOTW+1)'(dot_reg);
            sx_reg[S_P4] <= 64'(tplus) << 31;
            sr_reg[S_P4] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cm_reg[S_P4][i] <= 64'(cr3_reg[i][64] ? -cr3_reg[i] : cr3_reg[i]);
                cs_reg[S_P4][i] <= cr3_reg[i][64];
            end

            for (int k = S_P4 + 1; k <= S_SQ_END; k++)
            begin
                st = sqrt_step(sx_reg[k-1], sr_reg[k-1], 64'd1 << (2 * (SQN - (k - S_P4))));
                sx_reg[k] <= st.x;
                sr_reg[k] <= st.r;
                cm_reg[k] <= cm_reg[k-1];
            end
            for (int k = S_P4 + 1; k <= S_DV_END; k++)
            begin
                cs_reg[k] <= cs_reg[k-1];
            end

            // Cross product divided by s, rounded half away from zero.
            for (int i = 0; i < 3; i++)
            begin
                num = cm_reg[S_SQ_END][i] + {33'b0, sr_reg[S_SQ_END][31:1]};
                dr_reg[S_DI][i] <= 34'(num[63:40]);
                dl_reg[S_DI][i] <= num[39:0];
                dq_reg[S_DI][i] <= '0;
            end
            sv_reg[S_DI] <= sr_reg[S_SQ_END][31:0];

            for (int k = S_DI + 1; k <= S_DV_END; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dt = div_step(dr_reg[k-1][i], dl_reg[k-1][i][39], sv_reg[k-1]);
                    dr_reg[k][i] <= dt.r;
                    dl_reg[k][i] <= {dl_reg[k-1][i][38:0], 1'b0};
                    dq_reg[k][i] <= {dq_reg[k-1][i][38:0], dt.q};
                end
                sv_reg[k] <= sv_reg[k-1];
            end

            unique case (code_reg[S_DV_END])
                CASE_IDENTITY:
                begin
                    raw_reg[0] <= RAW_W'(64'sd1 <<< 30);
                    raw_reg[1] <= '0;
                    raw_reg[2] <= '0;
                    raw_reg[3] <= '0;
                end
                CASE_FALLBACK, CASE_GENAXIS:
                begin
                    raw_reg[0] <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        raw_reg[i+1] <= RAW_W'(axr_reg[S_DV_END][i]);
                    end
                end
                CASE_GENERAL:
                begin
                    raw_reg[0] <= $signed(RAW_W'(sv_reg[S_DV_END] >> 1));
                    for (int i = 0; i < 3; i++)
                    begin
                        if (cs_reg[S_DV_END][i])
                        begin
                            raw_reg[i+1] <= -$signed(RAW_W'(dq_reg[S_DV_END][i]));
                        end
                        else
                        begin
                            raw_reg[i+1] <= $signed(RAW_W'(dq_reg[S_DV_END][i]));
                        end
                    end
                end
            endcase

            // Q2.30 down to the output fraction, then cut to the field width.
            for (int i = 0; i < 4; i++)
            begin
                mag33 = qo[i][31] ? 33'(-qo[i]) : 33'(qo[i]);
                rnd33 = (mag33 + HALF) >> RSH;
                val33 = qo[i][31] ? -rnd33 : rnd33;
                oq_reg[i] <= val33[CB-1:0];
            end
        end
    end

    assign rsp.valid     = vld_reg[S_OUT];
    assign rsp.quat_w    = oq_reg[0];
    assign rsp.quat_x    = oq_reg[1];
    assign rsp.quat_y    = oq_reg[2];
    assign rsp.quat_z    = oq_reg[3];
    assign rsp.case_code = code_reg[S_OUT];

endmodule
`default_nettype wire

[hdl/saq_checker.sv]
`default_nettype none
`include "shortest_arc_quaternion_macros.svh"
module saq_checker import saq_pkg::*; #(
    parameter int COMPONENT_BITS = 16
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_ready,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [COMPONENT_BITS-1:0] rsp_quat_w,
    input wire logic [COMPONENT_BITS-1:0] rsp_quat_x,
    input wire logic [COMPONENT_BITS-1:0] rsp_quat_y,
    input wire logic [COMPONENT_BITS-1:0] rsp_quat_z,
    input wire logic [1:0]                rsp_case_code
);

    // A waiting result beat keeps its whole payload.
    `SAQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_x) && $stable(rsp_quat_y) && $stable(rsp_quat_z) && $stable(rsp_case_code), "result beat changed while stalled")

    // The input side stalls only behind a waiting result beat.
    `SAQ_ASSERT_NOW(a_ready_rule, 1'b1, req_ready == (!rsp_valid || rsp_ready), "input ready does not follow the output side")

    `SAQ_ASSERT_NOW(a_identity, rsp_valid && rsp_case_code == CASE_IDENTITY, rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0, "identity result with a nonzero vector part")

    // A half turn has no scalar part.
    `SAQ_ASSERT_NOW(a_half_turn, rsp_valid && (rsp_case_code == CASE_FALLBACK || rsp_case_code == CASE_GENAXIS), rsp_quat_w == '0, "half turn with nonzero w")

endmodule

bind shortest_arc_quaternion saq_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_saq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_quat_w    (rsp.quat_w),
    .rsp_quat_x    (rsp.quat_x),
    .rsp_quat_y    (rsp.quat_y),
    .rsp_quat_z    (rsp.quat_z),
    .rsp_case_code (rsp.case_code)
);
`default_nettype wire

[test/tb_shortest_arc_quaternion.sv]
`timescale 1ns / 100ps
module tb_shortest_arc_quaternion;
    import saq_pkg::*;

    localparam int  PIPE_DEPTH  = 221;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint ONE_Q30  = 64'sd1 << 30;

    typedef longint vec4_t[4];

    typedef struct {
        logic signed [15:0] src[3];
        logic signed [15:0] dst[3];
        logic signed [15:0] axis[3];
    } arc_item_t;

    typedef struct {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        case_t       code;
    } quat_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    quat_t expected_quats[$];

    saq_in_if  #(16) req_if();
    saq_out_if #(16) rsp_if();

    shortest_arc_quaternion #(
        .COMPONENT_BITS (16),
        .FRACTION_BITS  (14)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint round_shift(input longint v, input int k);
        longint unsigned m;
        if (k <= 0)
            return v;
        m = (magn(v) + (64'd1 << (k - 1))) >> k;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned m;
        m = (magn(num) + den / 2) / den;
        return (num < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Scales n components to unit length in Q2.30 after bringing the largest
    // magnitude into [2^29, 2^30).
    function automatic void unit_vec(input vec4_t v, input int n, output vec4_t o);
        longint unsigned m[4];
        longint unsigned top;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned qv;
        int up;
        int down;
        top = 0;
        sum = 0;
        up = 0;
        down = 0;
        for (int i = 0; i < 4; i++)
        begin
            o[i] = 0;
            m[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            m[i] = magn(v[i]);
            if (m[i] > top)
                top = m[i];
        end
        if (top == 0)
            return;
        while (top < (64'd1 << 29))
        begin
            top = top << 1;
            up++;
        end
        while (top >= (64'd1 << 30))
        begin
            top = top >> 1;
            down++;
        end
        for (int i = 0; i < n; i++)
        begin
            m[i] = (up != 0) ? (m[i] << up) : (m[i] >> down);
            sum += m[i] * m[i];
        end
        len = isqrt(sum);
        for (int i = 0; i < n; i++)
        begin
            qv = ((m[i] << 30) + len / 2) / len;
            o[i] = (v[i] < 0) ? -longint'(qv) : longint'(qv);
        end
    endfunction

    function automatic quat_t predict_arc(input arc_item_t it);
        vec4_t a;
        vec4_t b;
        vec4_t f;
        vec4_t na;
        vec4_t nb;
        vec4_t ax;
        vec4_t q;
        vec4_t raw;
        longint d60;
        longint dot;
        longint unsigned t;
        longint unsigned s;
        quat_t r;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = 0;
            b[i] = 0;
            f[i] = 0;
            ax[i] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            a[i] = it.src[i];
            b[i] = it.dst[i];
            f[i] = it.axis[i];
        end
        unit_vec(a, 3, na);
        unit_vec(b, 3, nb);
        d60 = na[0] * nb[0] + na[1] * nb[1] + na[2] * nb[2];
        dot = round_shift(d60, 30);
        if (dot >= ONE_Q30)
        begin
            q[0] = ONE_Q30;
            q[1] = 0;
            q[2] = 0;
            q[3] = 0;
            r.code = CASE_IDENTITY;
        end
        else if (dot < -ONE_Q30 + (64'sd1 << 16))
        begin
            if (f[0] != 0 || f[1] != 0 || f[2] != 0)
            begin
                ax = f;
                r.code = CASE_FALLBACK;
            end
            else
            begin
                ax[1] = -a[2];
                ax[2] = a[1];
                if (ax[1] == 0 && ax[2] == 0)
                begin
                    ax[0] = a[2];
                    ax[1] = 0;
                    ax[2] = -a[0];
                end
                r.code = CASE_GENAXIS;
            end
            unit_vec(ax, 3, raw);
            q[0] = 0;
            q[1] = raw[0];
            q[2] = raw[1];
            q[3] = raw[2];
        end
        else
        begin
            t = 2 * (ONE_Q30 + dot);
            s = isqrt(t << 30);
            raw[0] = longint'(s / 2);
            raw[1] = round_div(na[1] * nb[2] - na[2] * nb[1], s);
            raw[2] = round_div(na[2] * nb[0] - na[0] * nb[2], s);
            raw[3] = round_div(na[0] * nb[1] - na[1] * nb[0], s);
            unit_vec(raw, 4, q);
            r.code = CASE_GENERAL;
        end
        r.w = 16'(round_shift(q[0], 16));
        r.x = 16'(round_shift(q[1], 16));
        r.y = 16'(round_shift(q[2], 16));
        r.z = 16'(round_shift(q[3], 16));
        return r;
    endfunction

    task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    // Drives one beat after a random idle gap, if any; valid stays high across back-to-back beats.
    task automatic send_arc(input arc_item_t it);
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
            while ($urandom_range(99) < send_idle_pct && gap < 20)
                gap++;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.src_x      <= it.src[0];
        req_if.src_y      <= it.src[1];
        req_if.src_z      <= it.src[2];
        req_if.to_x       <= it.dst[0];
        req_if.to_y       <= it.dst[1];
        req_if.to_z       <= it.dst[2];
        req_if.fallback_x <= it.axis[0];
        req_if.fallback_y <= it.axis[1];
        req_if.fallback_z <= it.axis[2];
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_quats.push_back(predict_arc(it));
    endtask

    task automatic go_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic arc_item_t make_item(input int sx, sy, sz, tx, ty, tz, fx, fy, fz);
        arc_item_t it;
        it.src[0] = 16'(sx);
        it.src[1] = 16'(sy);
        it.src[2] = 16'(sz);
        it.dst[0] = 16'(tx);
        it.dst[1] = 16'(ty);
        it.dst[2] = 16'(tz);
        it.axis[0] = 16'(fx);
        it.axis[1] = 16'(fy);
        it.axis[2] = 16'(fz);
        return it;
    endfunction

    function automatic int rand_comp(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic arc_item_t random_arc();
        arc_item_t it;
        int kind;
        int span;
        int k;
        kind = $urandom_range(9);
        span = ($urandom_range(3) == 0) ? 64 : 32767;
        for (int i = 0; i < 3; i++)
        begin
            it.src[i] = 16'($urandom);
            it.dst[i] = 16'($urandom);
            it.axis[i] = ($urandom_range(1) == 0) ? 16'h0 : 16'($urandom);
        end
        case (kind)
            0, 1:
            begin
                // Exactly opposite pair, fallback given or not.
                k = $urandom_range(1, 2);
                for (int i = 0; i < 3; i++)
                begin
                    it.src[i] = 16'(rand_comp(span / 2));
                    it.dst[i] = 16'(-k * int'(it.src[i]));
                end
                if ($urandom_range(2) == 0)
                begin
                    it.src[1] = 16'h0;
                    it.src[2] = 16'h0;
                    it.dst[1] = 16'h0;
                    it.dst[2] = 16'h0;
                end
            end
            2:
            begin
                // Parallel pair.
                k = $urandom_range(1, 2);
                for (int i = 0; i < 3; i++)
                begin
                    it.src[i] = 16'(rand_comp(span / 2));
                    it.dst[i] = 16'(k * int'(it.src[i]));
                end
            end
            3:
            begin
                // Nearly parallel or nearly opposite.
                for (int i = 0; i < 3; i++)
                begin
                    it.src[i] = 16'(rand_comp(16000));
                    it.dst[i] = 16'(int'(it.src[i]) + rand_comp(3));
                end
                if ($urandom_range(1) == 0)
                    for (int i = 0; i < 3; i++)
                        it.dst[i] = 16'(-int'(it.dst[i]));
            end
            4:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    it.src[i] = 16'(rand_comp(span));
                    it.dst[i] = ($urandom_range(3) == 0) ? 16'h0 : 16'(rand_comp(span));
                end
                if ($urandom_range(3) == 0)
                    for (int i = 0; i < 3; i++)
                        it.src[i] = 16'h0;
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_quats.size() == 0)
            begin
                $display("error at %0t: result beat with nothing expected", $realtime);
                errors++;
            end
            else
            begin
                quat_t want;
                want = expected_quats.pop_front();
                if (rsp_if.quat_w !== want.w)
                    report("quat_w", rsp_if.quat_w, want.w);
                if (rsp_if.quat_x !== want.x)
                    report("quat_x", rsp_if.quat_x, want.x);
                if (rsp_if.quat_y !== want.y)
                    report("quat_y", rsp_if.quat_y, want.y);
                if (rsp_if.quat_z !== want.z)
                    report("quat_z", rsp_if.quat_z, want.z);
                if (rsp_if.case_code !== want.code)
                    report("case_code", 16'(rsp_if.case_code), 16'(want.code));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        send_arc(make_item(100, 200, 300, 100, 200, 300, 0, 0, 0));
        send_arc(make_item(0, 0, 0, 5, 6, 7, 0, 0, 0));
        send_arc(make_item(5, 6, 7, 0, 0, 0, 0, 0, 0));
        send_arc(make_item(0, 0, 0, 0, 0, 0, 1, 2, 3));
        send_arc(make_item(32767, 0, 0, -32767, 0, 0, 0, 0, 0));
        send_arc(make_item(-32768, 0, 0, 32767, 0, 0, 0, 0, 0));
        send_arc(make_item(1000, 0, 0, -1000, 0, 0, 0, 0, 1));
        send_arc(make_item(0, 1, 0, 0, -1, 0, 0, 0, 0));
        send_arc(make_item(0, 0, -32768, 0, 0, 32767, -32768, -32768, -32768));
        send_arc(make_item(3, 4, 5, -3, -4, -5, 32767, 32767, 32767));
        send_arc(make_item(32767, 0, 0, 32767, 1, 0, 0, 0, 0));
        send_arc(make_item(32767, 0, 0, 0, 32767, 0, 0, 0, 0));
        send_arc(make_item(32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0));
        send_arc(make_item(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0));
        send_arc(make_item(-32768, 32767, -1, 1, -32768, 32767, -1, 1, -32768));
        send_arc(make_item(1, 0, 0, 0, 0, 1, 0, 0, 0));
        send_arc(make_item(1, 1, 1, -1, -1, -1, 0, 32767, 0));
        send_arc(make_item(12345, -23456, 7, -321, 999, 32000, 0, 0, 0));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
            send_arc(random_arc());
    endtask

    task automatic test_drain_pause();
        go_idle();
        while (expected_quats.size() != 0)
            @(posedge clk);
        send_arc(make_item(-7, 9, 11, 7, -9, -11, 0, 0, 0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_if.valid = 1'b0;
        req_if.src_x = '0;
        req_if.src_y = '0;
        req_if.src_z = '0;
        req_if.to_x = '0;
        req_if.to_y = '0;
        req_if.to_z = '0;
        req_if.fallback_x = '0;
        req_if.fallback_y = '0;
        req_if.fallback_z = '0;
        rsp_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 280);
        test_random_phase(51, 0, 270);
        test_drain_pause();
        test_random_phase(0, 51, 270);
        test_random_phase(22, 22, 270);
        go_idle();

        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
